/* rtl/tcf_pkg.sv */
// Shared widths, register codes, sequencer states and the arctangent table of the tilt filter.
package tcf_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ANGLE_WIDTH_DEF  = 20;

    localparam int SAMPLE_W  = 16;
    localparam int OUT_W     = 20;
    localparam int BW_W      = 17;
    localparam int GAIN_W    = 16;
    localparam int OFS_W     = 17;
    localparam int CFG_W     = 17;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BLEND_WEIGHT    = 2'd0,
        CFG_GYRO_GAIN       = 2'd1,
        CFG_VERTICAL_OFFSET = 2'd2
    } cfg_index_t;

    localparam logic [BW_W-1:0]   BLEND_RESET  = 17'd64225;
    localparam logic [BW_W-1:0]   BLEND_ONE    = 17'd65536;
    localparam logic [GAIN_W-1:0] GAIN_RESET   = 16'd1001;
    localparam logic [OFS_W-1:0]  OFFSET_RESET = 17'd23040;

    localparam int CW           = 27;
    localparam int ZW           = 27;
    localparam int CORDIC_SCALE = 8;
    localparam int ZSHIFT       = 8;
    localparam int ZROUND       = 128;
    localparam int ACC_W        = ZW - ZSHIFT;
    localparam int ATAN_IDX_W   = 5;
    localparam logic signed [ZW-1:0] DEG180_Q16 = ZW'(11796480);

    localparam int MUL_LO_W   = 17;
    localparam int U_W        = GAIN_W + SAMPLE_W;
    localparam int P_W        = 49;
    localparam int P_HI_W     = P_W - SAMPLE_W;
    localparam int DIV_SHIFT  = 11;
    localparam int M_W        = P_W - DIV_SHIFT;
    localparam int D_W        = M_W - 1;
    localparam int REM_W      = 7;
    localparam int INC_W      = 32;
    localparam int ROUND_HALF = 32768;
    localparam int BLEND_SHIFT = 16;
    localparam logic [P_W-1:0]   ROUND_BIAS = 49'd128000;
    localparam logic [REM_W:0]   DIV_CONST  = 8'd125;

    localparam int CNT_W = 6;
    localparam logic [CNT_W-1:0] DT_LAST    = 6'd15;
    localparam logic [CNT_W-1:0] GZ_LAST    = 6'd15;
    localparam logic [CNT_W-1:0] DIV_LAST   = 6'd36;
    localparam logic [CNT_W-1:0] BLEND_LAST = 6'd16;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_DT,
        ST_MUL_GZ,
        ST_ROUND,
        ST_DIVIDE,
        ST_PRED,
        ST_DIFF,
        ST_BLEND,
        ST_RND,
        ST_MIX,
        ST_DONE
    } tcf_state_t;

    // Arctangent of 2^-i in 1/65536 degree.
    function automatic logic signed [ZW-1:0] atan_q16(input logic [ATAN_IDX_W-1:0] idx);
        logic signed [ZW-1:0] val;
        case (idx)
            5'd0:    val = ZW'(2949120);
            5'd1:    val = ZW'(1740967);
            5'd2:    val = ZW'(919879);
            5'd3:    val = ZW'(466945);
            5'd4:    val = ZW'(234379);
            5'd5:    val = ZW'(117304);
            5'd6:    val = ZW'(58666);
            5'd7:    val = ZW'(29335);
            5'd8:    val = ZW'(14668);
            5'd9:    val = ZW'(7334);
            5'd10:   val = ZW'(3667);
            5'd11:   val = ZW'(1833);
            5'd12:   val = ZW'(917);
            5'd13:   val = ZW'(458);
            5'd14:   val = ZW'(229);
            5'd15:   val = ZW'(115);
            5'd16:   val = ZW'(57);
            5'd17:   val = ZW'(29);
            5'd18:   val = ZW'(14);
            5'd19:   val = ZW'(7);
            5'd20:   val = ZW'(4);
            5'd21:   val = ZW'(2);
            5'd22:   val = ZW'(1);
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

/* rtl/tcf_channels.sv */
// Valid/ready channel interfaces for IMU samples and filtered tilt results.
interface tcf_sample_if
    import tcf_pkg::*;
;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] accel_x;
    logic signed [SAMPLE_W-1:0] accel_y;
    logic signed [SAMPLE_W-1:0] gyro_z;
    logic [SAMPLE_W-1:0]        elapsed_ms;
    logic                       read_ok;

    modport source (output valid, output accel_x, output accel_y, output gyro_z,
                     output elapsed_ms, output read_ok, input ready);
    modport sink (input valid, input accel_x, input accel_y, input gyro_z,
                  input elapsed_ms, input read_ok, output ready);
endinterface

interface tcf_result_if
    import tcf_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] tilt_angle;
    logic                    sensor_ok;

    modport source (output valid, output tilt_angle, output sensor_ok, input ready);
    modport sink (input valid, input tilt_angle, input sensor_ok, output ready);
endinterface

/* rtl/tilt_complementary_filter.sv */
// Tilt complementary filter: CORDIC accelerometer angle blended with the integrated gyro rate.
//
// A sample transaction with read_ok set runs through these steps in order: a bit-serial gain
// times elapsed-time product, a serial product with the gyro rate, the one-bit-per-cycle
// division by 125 that scales the gyro increment, the serial blend multiply by the weight, and
// the add and saturate steps between them. The CORDIC runs its CORDIC_STEPS iterations
// alongside the first multiplies. A failed read repeats the last reported angle. The result
// sits in an output register, so a waiting result stalls the block only when the next one is
// ready to leave.
module tilt_complementary_filter
    import tcf_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
    parameter int ANGLE_WIDTH  = ANGLE_WIDTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    tcf_sample_if.sink           sample,
    tcf_result_if.source         result,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int INC_MAXW = (ANGLE_WIDTH > INC_W) ? ANGLE_WIDTH : INC_W;
    localparam int PRED_W   = INC_MAXW + 1;
    localparam int DIFF_W   = PRED_W + 1;
    localparam int MH_W     = DIFF_W + 1;
    localparam int PROD_W   = MH_W + MUL_LO_W;
    localparam int SUM_W    = ((ANGLE_WIDTH > OUT_W) ? ANGLE_WIDTH : OUT_W) + 1;
    localparam int CSTEP_W  = $clog2(CORDIC_STEPS + 1);

    localparam logic [CSTEP_W-1:0] CSTEP_LAST = CSTEP_W'(CORDIC_STEPS - 1);
    localparam logic signed [MH_W:0] FILT_MAX =
        {{(MH_W + 2 - ANGLE_WIDTH){1'b0}}, {(ANGLE_WIDTH - 1){1'b1}}};
    localparam logic signed [MH_W:0] FILT_MIN = ~FILT_MAX;
    localparam logic signed [SUM_W-1:0] OUT_MAX_S =
        {{(SUM_W - OUT_W + 1){1'b0}}, {(OUT_W - 1){1'b1}}};
    localparam logic signed [SUM_W-1:0] OUT_MIN_S = ~OUT_MAX_S;

    tcf_state_t state_reg, state_next;

    logic accept;
    logic out_load;

    logic [BW_W-1:0]          blend_reg;
    logic [GAIN_W-1:0]        gain_reg;
    logic signed [OFS_W-1:0]  offset_reg;
    logic [BW_W-1:0]          alpha_sat;

    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic signed [MH_W-1:0]   mh_reg, mh_next;
    logic signed [MH_W-1:0]   mcand_reg, mcand_next;
    logic [MUL_LO_W-1:0]      ml_reg, ml_next;
    logic [SAMPLE_W-1:0]      gz_reg, gz_next;
    logic [SAMPLE_W-1:0]      ms_eff;
    logic                     mul_sub;
    logic signed [MH_W:0]     mul_sum;
    logic signed [MH_W-1:0]   step_hi;
    logic [MUL_LO_W-1:0]      step_lo;

    logic [P_W-1:0]           p_val;
    logic [P_W-1:0]           n_val;
    logic [M_W-1:0]           m_val;
    logic [D_W-1:0]           div_reg, div_next;
    logic [REM_W-1:0]         rem_reg, rem_next;
    logic                     neg_reg, neg_next;
    logic [REM_W:0]           div_shift;
    logic [REM_W:0]           div_diff;
    logic                     div_ge;

    logic [D_W:0]             inc_full;
    logic signed [INC_W-1:0]  inc_val;
    logic signed [PRED_W-1:0] pred_val;
    logic signed [PROD_W-1:0] prod_val;
    logic signed [PROD_W-1:0] prod_rnd;
    logic signed [MH_W:0]     mix_val;

    logic signed [ANGLE_WIDTH-1:0] filt_reg, filt_next;
    logic signed [SUM_W-1:0]  rep_sum;
    logic signed [OUT_W-1:0]  rep_val;
    logic signed [OUT_W-1:0]  last_rep_reg, last_rep_next;
    logic signed [OUT_W-1:0]  out_angle_reg, out_angle_next;
    logic                     out_ok_reg, out_ok_next;
    logic                     out_valid_reg, out_valid_next;
    logic                     ok_reg, ok_next;

    logic signed [CW-1:0]     cx_reg, cx_next, cy_reg, cy_next;
    logic signed [ZW-1:0]     cz_reg, cz_next;
    logic [CSTEP_W-1:0]       cstep_reg, cstep_next;
    logic                     cbusy_reg, cbusy_next;
    logic                     azero_reg, azero_next;
    logic signed [CW-1:0]     ax_s, ay_s;
    logic signed [CW-1:0]     cdx, cdy;
    logic signed [ZW-1:0]     cat;
    logic signed [ZW-1:0]     zsum;
    logic signed [ACC_W-1:0]  acc_val;

    assign accept   = sample.valid && sample.ready;
    assign out_load = !out_valid_reg || result.ready;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blend_reg  <= BLEND_RESET;
            gain_reg   <= GAIN_RESET;
            offset_reg <= OFFSET_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_BLEND_WEIGHT:    blend_reg  <= cfg_data;
                CFG_GYRO_GAIN:       gain_reg   <= cfg_data[GAIN_W-1:0];
                CFG_VERTICAL_OFFSET: offset_reg <= cfg_data;
                default:             ;
            endcase
        end
    end

    assign alpha_sat = (blend_reg > BLEND_ONE) ? BLEND_ONE : blend_reg;

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (sample.valid)
                begin
                    state_next = sample.read_ok ? ST_MUL_DT : ST_DONE;
                end
            end
            ST_MUL_DT:
            begin
                if (cnt_reg == DT_LAST)
                begin
                    state_next = ST_MUL_GZ;
                end
            end
            ST_MUL_GZ:
            begin
                if (cnt_reg == GZ_LAST)
                begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:  state_next = ST_DIVIDE;
            ST_DIVIDE:
            begin
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = ST_PRED;
                end
            end
            ST_PRED:   state_next = ST_DIFF;
            ST_DIFF:   state_next = ST_BLEND;
            ST_BLEND:
            begin
                if (cnt_reg == BLEND_LAST)
                begin
                    state_next = ST_RND;
                end
            end
            ST_RND:    state_next = ST_MIX;
            ST_MIX:    state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // Port outputs.
    always_comb
    begin
        sample.ready      = (state_reg == ST_IDLE);
        result.valid      = out_valid_reg;
        result.tilt_angle = out_angle_reg;
        result.sensor_ok  = out_ok_reg;
    end

    // Shared serial multiplier step: one multiplier bit per cycle.
    assign mul_sub = (state_reg == ST_MUL_GZ) && (cnt_reg == GZ_LAST);

    always_comb
    begin
        if (!ml_reg[0])
        begin
            mul_sum = {mh_reg[MH_W-1], mh_reg};
        end
        else if (mul_sub)
        begin
            mul_sum = {mh_reg[MH_W-1], mh_reg} - {mcand_reg[MH_W-1], mcand_reg};
        end
        else
        begin
            mul_sum = {mh_reg[MH_W-1], mh_reg} + {mcand_reg[MH_W-1], mcand_reg};
        end
    end

    assign step_hi = mul_sum[MH_W:1];
    assign step_lo = {mul_sum[0], ml_reg[MUL_LO_W-1:1]};
    assign ms_eff  = (sample.elapsed_ms == '0) ? SAMPLE_W'(1) : sample.elapsed_ms;

    // Rounding of the gyro product and the restoring divider by 125.
    assign p_val     = {mh_reg[P_HI_W-1:0], ml_reg[MUL_LO_W-1:1]};
    assign n_val     = p_val + ROUND_BIAS;
    assign m_val     = n_val[P_W-1:DIV_SHIFT];
    assign div_shift = {rem_reg, div_reg[D_W-1]};
    assign div_diff  = div_shift - DIV_CONST;
    assign div_ge    = (div_shift >= DIV_CONST);

    assign inc_full = {neg_reg, div_reg ^ {D_W{neg_reg}}};
    assign inc_val  = inc_full[INC_W-1:0];
    assign pred_val = PRED_W'(filt_reg) + PRED_W'(inc_val);
    assign prod_val = {mh_reg, ml_reg};
    assign prod_rnd = prod_val + PROD_W'(ROUND_HALF);
    assign mix_val  = (MH_W + 1)'(acc_val) + {mcand_reg[MH_W-1], mcand_reg};
    assign rep_sum  = SUM_W'(filt_reg) + SUM_W'(offset_reg);

    always_comb
    begin
        if (rep_sum > OUT_MAX_S)
        begin
            rep_val = OUT_MAX_S[OUT_W-1:0];
        end
        else if (rep_sum < OUT_MIN_S)
        begin
            rep_val = OUT_MIN_S[OUT_W-1:0];
        end
        else
        begin
            rep_val = rep_sum[OUT_W-1:0];
        end
    end

    // Datapath next values.
    always_comb
    begin
        cnt_next       = cnt_reg;
        mh_next        = mh_reg;
        ml_next        = ml_reg;
        mcand_next     = mcand_reg;
        gz_next        = gz_reg;
        div_next       = div_reg;
        rem_next       = rem_reg;
        neg_next       = neg_reg;
        filt_next      = filt_reg;
        ok_next        = ok_reg;
        last_rep_next  = last_rep_reg;
        out_angle_next = out_angle_reg;
        out_ok_next    = out_ok_reg;
        out_valid_next = out_valid_reg && !result.ready;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cnt_next   = '0;
                    mh_next    = '0;
                    ml_next    = {1'b0, ms_eff};
                    mcand_next = MH_W'(gain_reg);
                    gz_next    = sample.gyro_z;
                    ok_next    = sample.read_ok;
                end
            end
            ST_MUL_DT:
            begin
                cnt_next = cnt_reg + 1'b1;
                mh_next  = step_hi;
                ml_next  = step_lo;
                if (cnt_reg == DT_LAST)
                begin
                    cnt_next   = '0;
                    mh_next    = '0;
                    ml_next    = {1'b0, gz_reg};
                    mcand_next = MH_W'({step_hi[GAIN_W-1:0], step_lo[MUL_LO_W-1:1]});
                end
            end
            ST_MUL_GZ:
            begin
                cnt_next = cnt_reg + 1'b1;
                mh_next  = step_hi;
                ml_next  = step_lo;
            end
            ST_ROUND:
            begin
                cnt_next = '0;
                rem_next = '0;
                neg_next = m_val[M_W-1];
                div_next = m_val[D_W-1:0] ^ {D_W{m_val[M_W-1]}};
            end
            ST_DIVIDE:
            begin
                cnt_next = cnt_reg + 1'b1;
                rem_next = div_ge ? div_diff[REM_W-1:0] : div_shift[REM_W-1:0];
                div_next = {div_reg[D_W-2:0], div_ge};
            end
            ST_PRED:
            begin
                mcand_next = MH_W'(pred_val);
            end
            ST_DIFF:
            begin
                cnt_next   = '0;
                mh_next    = '0;
                ml_next    = alpha_sat;
                mcand_next = mcand_reg - MH_W'(acc_val);
            end
            ST_BLEND:
            begin
                cnt_next = cnt_reg + 1'b1;
                mh_next  = step_hi;
                ml_next  = step_lo;
            end
            ST_RND:
            begin
                mcand_next = prod_rnd[BLEND_SHIFT +: MH_W];
            end
            ST_MIX:
            begin
                if (mix_val > FILT_MAX)
                begin
                    filt_next = FILT_MAX[ANGLE_WIDTH-1:0];
                end
                else if (mix_val < FILT_MIN)
                begin
                    filt_next = FILT_MIN[ANGLE_WIDTH-1:0];
                end
                else
                begin
                    filt_next = mix_val[ANGLE_WIDTH-1:0];
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    out_ok_next    = ok_reg;
                    out_angle_next = ok_reg ? rep_val : last_rep_reg;
                    last_rep_next  = ok_reg ? rep_val : last_rep_reg;
                end
            end
            default: ;
        endcase
    end

    // Vectoring CORDIC, one iteration per cycle, started with each good sample.
    assign ax_s = {{(CW - SAMPLE_W - CORDIC_SCALE){sample.accel_x[SAMPLE_W-1]}},
                   sample.accel_x, {CORDIC_SCALE{1'b0}}};
    assign ay_s = {{(CW - SAMPLE_W - CORDIC_SCALE){sample.accel_y[SAMPLE_W-1]}},
                   sample.accel_y, {CORDIC_SCALE{1'b0}}};
    assign cdx  = cy_reg >>> cstep_reg;
    assign cdy  = cx_reg >>> cstep_reg;
    assign cat  = atan_q16(ATAN_IDX_W'(cstep_reg));
    assign zsum = cz_reg + ZW'(ZROUND);
    assign acc_val = azero_reg ? '0 : zsum[ZW-1:ZSHIFT];

    always_comb
    begin
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        cz_next    = cz_reg;
        cstep_next = cstep_reg;
        cbusy_next = cbusy_reg;
        azero_next = azero_reg;
        if (accept && sample.read_ok)
        begin
            cbusy_next = 1'b1;
            cstep_next = '0;
            azero_next = (sample.accel_x == '0) && (sample.accel_y == '0);
            if (sample.accel_y[SAMPLE_W-1])
            begin
                cx_next = -ay_s;
                cy_next = -ax_s;
                cz_next = sample.accel_x[SAMPLE_W-1] ? -DEG180_Q16 : DEG180_Q16;
            end
            else
            begin
                cx_next = ay_s;
                cy_next = ax_s;
                cz_next = '0;
            end
        end
        else if (cbusy_reg)
        begin
            cstep_next = cstep_reg + 1'b1;
            if (cstep_reg == CSTEP_LAST)
            begin
                cbusy_next = 1'b0;
            end
            if (!cy_reg[CW-1])
            begin
                cx_next = cx_reg + cdx;
                cy_next = cy_reg - cdy;
                cz_next = cz_reg + cat;
            end
            else
            begin
                cx_next = cx_reg - cdx;
                cy_next = cy_reg + cdy;
                cz_next = cz_reg - cat;
            end
        end
    end

    // Control and state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            cbusy_reg     <= 1'b0;
            cstep_reg     <= '0;
            filt_reg      <= '0;
            last_rep_reg  <= '0;
            out_valid_reg <= 1'b0;
            ok_reg        <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            cbusy_reg     <= cbusy_next;
            cstep_reg     <= cstep_next;
            filt_reg      <= filt_next;
            last_rep_reg  <= last_rep_next;
            out_valid_reg <= out_valid_next;
            ok_reg        <= ok_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        mh_reg        <= mh_next;
        ml_reg        <= ml_next;
        mcand_reg     <= mcand_next;
        gz_reg        <= gz_next;
        div_reg       <= div_next;
        rem_reg       <= rem_next;
        neg_reg       <= neg_next;
        out_angle_reg <= out_angle_next;
        out_ok_reg    <= out_ok_next;
        cx_reg        <= cx_next;
        cy_reg        <= cy_next;
        cz_reg        <= cz_next;
        azero_reg     <= azero_next;
    end

    a_cordic_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIFF) |-> !cbusy_reg)
        else $error("CORDIC angle used before the iterations finished");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !sample.ready)
        else $error("Sample taken while a transaction is still in progress");

    a_filt_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_MIX) |=> $stable(filt_reg))
        else $error("Filtered angle changed outside the blend step");

    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIVIDE) |-> (rem_reg < DIV_CONST))
        else $error("Divider remainder out of range");

endmodule

/* dv/tilt_complementary_filter_checker.sv */
`timescale 1ns / 100ps
// Checker that predicts every tilt result of the complementary filter and compares it.
module tilt_complementary_filter_checker
    import tcf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    tcf_sample_if                sample,
    tcf_result_if                result,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output int                   fail_count,
    output int                   pending,
    output int                   sample_count,
    output int                   failed_read_count,
    output int                   result_count
);

    typedef struct {
        logic signed [OUT_W-1:0] angle;
        logic                    ok;
    } tilt_result_t;

    localparam int     ROTATIONS = 16;
    localparam longint HALF_TURN = 64'sd11796480;
    localparam longint ANGLE_MAX = 64'sd524287;
    localparam longint ANGLE_MIN = -64'sd524288;
    localparam longint OUT_MAX   = 64'sd524287;
    localparam longint OUT_MIN   = -64'sd524288;

    localparam longint ARCTAN_DEG_Q16 [ROTATIONS] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115
    };

    logic [BW_W-1:0]         weight_reg;
    logic [GAIN_W-1:0]       gain_reg;
    logic signed [OFS_W-1:0] offset_reg;
    longint                  filtered;
    logic signed [OUT_W-1:0] last_angle;
    tilt_result_t            tilt_expected_q[$];
    int                      errors;
    int                      samples;
    int                      failed_reads;
    int                      results;

    function automatic longint floor_div(input longint num, input longint den);
        if (num >= 0)
            return num / den;
        return -((-num - 1) / den) - 1;
    endfunction

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Vectoring rotation toward the positive x axis; returns atan2(ax, ay) in 1/256 degree.
    function automatic longint accel_angle(input longint ax, input longint ay);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        x = ay * 256;
        y = ax * 256;
        z = 0;
        if (ax == 0 && ay == 0)
            return 0;
        if (x < 0)
        begin
            z = (y >= 0) ? HALF_TURN : -HALF_TURN;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < ROTATIONS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0)
            begin
                x = x + dx;
                y = y - dy;
                z = z + ARCTAN_DEG_Q16[i];
            end
            else
            begin
                x = x - dx;
                y = y + dy;
                z = z - ARCTAN_DEG_Q16[i];
            end
        end
        return (z + 128) >>> 8;
    endfunction

    function automatic tilt_result_t filter_sample(input longint ax, input longint ay,
                                                   input longint gz, input longint ms,
                                                   input logic ok);
        tilt_result_t res;
        longint       acc;
        longint       inc;
        longint       pred;
        longint       alpha;
        longint       mix;
        longint       rep;
        if (!ok)
        begin
            res.angle = last_angle;
            res.ok    = 1'b0;
            return res;
        end
        if (ms == 0)
            ms = 1;
        acc   = accel_angle(ax, ay);
        inc   = floor_div(gz * longint'(gain_reg) * ms + 128000, 256000);
        pred  = filtered + inc;
        alpha = longint'(weight_reg);
        if (alpha > 65536)
            alpha = 65536;
        mix      = (alpha * pred + (65536 - alpha) * acc + 32768) >>> 16;
        filtered = clamp(mix, ANGLE_MIN, ANGLE_MAX);
        rep      = clamp(filtered + longint'(offset_reg), OUT_MIN, OUT_MAX);
        last_angle = OUT_W'(rep);
        res.angle  = OUT_W'(rep);
        res.ok     = 1'b1;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        tilt_result_t exp_res;
        if (!rst_n)
        begin
            weight_reg   = BLEND_RESET;
            gain_reg     = GAIN_RESET;
            offset_reg   = OFFSET_RESET;
            filtered     = 0;
            last_angle   = '0;
            errors       = 0;
            samples      = 0;
            failed_reads = 0;
            results      = 0;
            tilt_expected_q.delete();
        end
        else
        begin
            if (sample.valid && sample.ready)
            begin
                tilt_expected_q.push_back(filter_sample(longint'(sample.accel_x),
                    longint'(sample.accel_y), longint'(sample.gyro_z),
                    longint'(sample.elapsed_ms), sample.read_ok));
                samples++;
                if (!sample.read_ok)
                    failed_reads++;
            end
            if (result.valid && result.ready)
            begin
                results++;
                if (tilt_expected_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result transaction, angle %0d ok %0b",
                             $time, result.tilt_angle, result.sensor_ok);
                end
                else
                begin
                    exp_res = tilt_expected_q.pop_front();
                    if (result.tilt_angle !== exp_res.angle)
                    begin
                        errors++;
                        $display("%0t: tilt_angle mismatch, expected %0d, actual %0d",
                                 $time, exp_res.angle, result.tilt_angle);
                    end
                    if (result.sensor_ok !== exp_res.ok)
                    begin
                        errors++;
                        $display("%0t: sensor_ok mismatch, expected %0b, actual %0b",
                                 $time, exp_res.ok, result.sensor_ok);
                    end
                end
            end
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_BLEND_WEIGHT:    weight_reg = BW_W'(cfg_data);
                    CFG_GYRO_GAIN:       gain_reg   = GAIN_W'(cfg_data);
                    CFG_VERTICAL_OFFSET: offset_reg = OFS_W'(cfg_data);
                    default:             ;
                endcase
            end
        end
        fail_count        <= errors;
        pending           <= tilt_expected_q.size();
        sample_count      <= samples;
        failed_read_count <= failed_reads;
        result_count      <= results;
    end

endmodule

/* dv/tilt_complementary_filter_tb.sv */
`timescale 1ns / 100ps
// Testbench top for the tilt complementary filter: clock, reset, stimulus and verdict.
module tilt_complementary_filter_tb;
    import tcf_pkg::*;

    localparam int                   RESET_CYCLES  = 9;
    localparam int                   DRAIN_CYCLES  = 120;
    localparam int                   STALL_LIMIT   = 4000;
    localparam int                   PHASES        = 8;
    localparam int                   PHASE_SAMPLES = 129;
    localparam logic [CFG_IDX_W-1:0] CFG_NO_REG    = 2'd3;

    localparam int SEND_IDLE_PCT [4] = '{0, 47, 0, 7};
    localparam int RECV_STALL_PCT [4] = '{0, 0, 47, 7};

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    int                   send_idle_pct;
    int                   recv_stall_pct;
    int                   idle_cycles;
    int                   fail_count;
    int                   pending;
    int                   sample_count;
    int                   failed_read_count;
    int                   result_count;

    tcf_sample_if smp_if ();
    tcf_result_if res_if ();

    tilt_complementary_filter u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (smp_if),
        .result    (res_if),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    tilt_complementary_filter_checker u_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .sample            (smp_if),
        .result            (res_if),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .fail_count        (fail_count),
        .pending           (pending),
        .sample_count      (sample_count),
        .failed_read_count (failed_read_count),
        .result_count      (result_count)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        res_if.ready <= rst_n && ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if ((smp_if.valid && smp_if.ready) || (res_if.valid && res_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_all_regs(input logic [CFG_W-1:0] weight, input logic [CFG_W-1:0] gain,
                                  input logic [CFG_W-1:0] offset);
        write_reg(CFG_BLEND_WEIGHT, weight);
        write_reg(CFG_GYRO_GAIN, gain);
        write_reg(CFG_VERTICAL_OFFSET, offset);
    endtask

    task automatic wait_drained();
        smp_if.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic send_sample(input logic signed [SAMPLE_W-1:0] ax,
                               input logic signed [SAMPLE_W-1:0] ay,
                               input logic signed [SAMPLE_W-1:0] gz,
                               input logic [SAMPLE_W-1:0] ms, input logic ok);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap != 0)
        begin
            smp_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        smp_if.valid      <= 1'b1;
        smp_if.accel_x    <= ax;
        smp_if.accel_y    <= ay;
        smp_if.gyro_z     <= gz;
        smp_if.elapsed_ms <= ms;
        smp_if.read_ok    <= ok;
        @(posedge clk);
        while (!smp_if.ready)
            @(posedge clk);
    endtask

    initial
    begin
        logic signed [SAMPLE_W-1:0] ax;
        logic signed [SAMPLE_W-1:0] ay;
        logic signed [SAMPLE_W-1:0] gz;
        logic [SAMPLE_W-1:0]        ms;
        logic                       ok;
        int                         mode;
        rst_n             <= 1'b0;
        cfg_wr_en         <= 1'b0;
        cfg_index         <= CFG_BLEND_WEIGHT;
        cfg_data          <= '0;
        smp_if.valid      <= 1'b0;
        smp_if.accel_x    <= '0;
        smp_if.accel_y    <= '0;
        smp_if.gyro_z     <= '0;
        smp_if.elapsed_ms <= '0;
        smp_if.read_ok    <= 1'b0;
        send_idle_pct     = 0;
        recv_stall_pct    = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_sample(16'sd1, 16'sd2, 16'sd3, 16'd4, 1'b0);
        send_sample(16'sd0, 16'sd0, 16'sd0, 16'd0, 1'b1);
        send_sample(16'sd1000, 16'sd16384, 16'sd100, 16'd10, 1'b1);
        send_sample(16'sd16384, -16'sd16384, -16'sd200, 16'd5, 1'b1);
        send_sample(-16'sd16384, -16'sd16384, 16'sd0, 16'd1, 1'b1);
        send_sample(16'sd0, -16'sd1000, 16'sd0, 16'd1, 1'b1);
        send_sample(16'sd32767, 16'sd32767, 16'sd32767, 16'd65535, 1'b1);
        send_sample(-16'sd32768, -16'sd32768, -16'sd32768, 16'd65535, 1'b1);
        send_sample(-16'sd32768, 16'sd32767, 16'sd1, 16'd0, 1'b1);
        send_sample(16'sd5, 16'sd6, 16'sd7, 16'd8, 1'b0);
        wait_drained();

        write_all_regs(17'd131071, 17'd65535, 17'd65535);
        send_sample(16'sd0, 16'sd100, 16'sd32767, 16'd65535, 1'b1);
        send_sample(16'sd0, 16'sd100, 16'sd32767, 16'd65535, 1'b1);
        wait_drained();
        write_reg(CFG_VERTICAL_OFFSET, CFG_W'(-65536));
        send_sample(16'sd0, 16'sd100, -16'sd32768, 16'd65535, 1'b1);
        send_sample(16'sd0, 16'sd100, -16'sd32768, 16'd65535, 1'b1);
        send_sample(16'sd0, 16'sd100, -16'sd32768, 16'd65535, 1'b0);
        wait_drained();
        write_reg(CFG_BLEND_WEIGHT, 17'd0);
        write_reg(CFG_GYRO_GAIN, 17'h1FFFF);
        write_reg(CFG_NO_REG, 17'h0ABCD);
        send_sample(16'sd100, -16'sd100, 16'sd32767, 16'd3, 1'b1);
        send_sample(-16'sd1, 16'sd0, 16'sd0, 16'd1, 1'b1);
        send_sample(16'sd1, 16'sd0, 16'sd0, 16'd1, 1'b1);
        wait_drained();

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: write_all_regs(BLEND_RESET, CFG_W'(GAIN_RESET), OFFSET_RESET);
                1: write_all_regs(17'd0, 17'd65535, CFG_W'(-46080));
                2: write_all_regs(BLEND_ONE, 17'd0, 17'd46080);
                3: write_all_regs(17'd131071, CFG_W'($urandom_range(0, 65535)), 17'd0);
                default: write_all_regs(CFG_W'($urandom_range(60000, 65536)),
                                        CFG_W'($urandom_range(0, 4000)),
                                        CFG_W'(int'($urandom_range(0, 92160)) - 46080));
            endcase
            send_idle_pct  = SEND_IDLE_PCT[p % 4];
            recv_stall_pct = RECV_STALL_PCT[p % 4];
            for (int n = 0; n < PHASE_SAMPLES; n++)
            begin
                mode = $urandom_range(0, 9);
                ax = SAMPLE_W'($urandom());
                ay = SAMPLE_W'($urandom());
                if (mode == 0)
                begin
                    ax = SAMPLE_W'(int'($urandom_range(0, 16)) - 8);
                    ay = SAMPLE_W'(int'($urandom_range(0, 16)) - 8);
                end
                else if (mode == 1)
                    ax = '0;
                else if (mode == 2)
                    ay = '0;
                if ($urandom_range(0, 1) == 0)
                    gz = SAMPLE_W'($urandom());
                else
                    gz = SAMPLE_W'(int'($urandom_range(0, 2048)) - 1024);
                mode = $urandom_range(0, 9);
                if (mode == 0)
                    ms = '0;
                else if (mode <= 6)
                    ms = SAMPLE_W'($urandom_range(1, 20));
                else if (mode <= 8)
                    ms = SAMPLE_W'($urandom_range(0, 1000));
                else
                    ms = SAMPLE_W'($urandom());
                ok = ($urandom_range(0, 99) >= 12);
                send_sample(ax, ay, gz, ms, ok);
            end
            wait_drained();
        end

        $display("Covered %0d IMU samples, %0d of them failed reads, over %0d phases",
                 sample_count, failed_read_count, PHASES);
        $display("of handshake pressure and register settings; %0d results compared.",
                 result_count);
        if (fail_count == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
